[src/pga_pkg.sv]
`default_nettype none
package pga_pkg;

	localparam int POS_W     = 32;
	localparam int MASS_W    = 24;
	localparam int G_W       = 16;
	localparam int MASS_FRAC = 8;

	localparam logic [G_W-1:0] G_RESET = 16'd3000;

	// Derived widths of the datapath.
	localparam int DIFF_W     = POS_W + 1;          // exact coordinate difference
	localparam int SQ_W       = 2 * DIFF_W + 1;     // dx^2 + dy^2
	localparam int ROOT_W     = DIFF_W + 1;         // floor(sqrt(S))
	localparam int ROOT_STEPS = ROOT_W;
	localparam int PROD_W     = 64;                 // G*m1*m2
	localparam int MAG_W      = 32;                 // force magnitude
	localparam int CX_W       = 64;                 // force component before clipping
	localparam int ACC_Q_W    = 33;                 // acceleration quotient bits kept
	localparam int LANES      = 4;

	typedef struct packed {
		logic signed [POS_W-1:0] first_pos_x;
		logic signed [POS_W-1:0] first_pos_y;
		logic signed [POS_W-1:0] second_pos_x;
		logic signed [POS_W-1:0] second_pos_y;
		logic [MASS_W-1:0]       first_mass;
		logic [MASS_W-1:0]       second_mass;
	} pair_t;

	typedef struct packed {
		logic signed [POS_W-1:0] force_x;
		logic signed [POS_W-1:0] force_y;
		logic signed [POS_W-1:0] first_accel_x;
		logic signed [POS_W-1:0] first_accel_y;
		logic signed [POS_W-1:0] second_accel_x;
		logic signed [POS_W-1:0] second_accel_y;
		logic                    degenerate;
		logic                    saturated;
	} result_t;

endpackage
`default_nettype wire

[src/pga_if.sv]
`default_nettype none
interface pga_pair_if;
	import pga_pkg::*;
	logic  valid;
	logic  ready;
	pair_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface pga_result_if;
	import pga_pkg::*;
	logic    valid;
	logic    ready;
	result_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

[src/pairwise_gravity_acceleration.sv]
// Pairwise 2D gravity: one word on the pair channel carries two bodies (Q15.16
// positions, Q16.8 masses); one word on the result channel returns the force on
// the first body, the acceleration increments F/m1 and -F/m2, and the
// degenerate and saturated flags. Both channels use a valid/ready handshake.
// The gravity constant is written through cfg_we/cfg_wdata and resets to
// 3000; write it only while the block is idle, which the block does not enforce.
// The block is a straight pipeline of 138 register stages, and a new pair is
// taken every cycle while the result side keeps up. The length is set by the
// bit-serial units, one quotient or root bit per stage: the square root (34
// stages, the force magnitude division running beside it), the component
// division by the distance (64 stages) and the four acceleration divisions by
// the masses (33 stages). Reset empties the pipeline; no result is pending
// afterwards.
// When the receiver stalls with a result waiting, every stage holds and the
// pair channel drops ready, so no word is lost or repeated.
`default_nettype none
module pairwise_gravity_acceleration #(
	parameter int FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [pga_pkg::G_W-1:0] cfg_wdata,
	pga_pair_if.sink              pair,
	pga_result_if.source          result
);
	import pga_pkg::*;

	// The force numerator is G*m1*m2 scaled up so that the quotient lands in
	// the position format.
	localparam int SH     = 3 * FRAC_BITS - 2 * MASS_FRAC;
	localparam int NUM_W  = PROD_W + SH;
	localparam int DIV_W  = (NUM_W > SQ_W + MAG_W) ? NUM_W : SQ_W + MAG_W;
	localparam int TW     = 2 * ROOT_W + 1;
	// Stage bookkeeping: three front stages, root/magnitude, component,
	// acceleration and the output register.
	localparam int NST    = 3 + (ROOT_STEPS + 1) + (CX_W + 1) + (ACC_Q_W + 1) + 1;

	typedef struct packed {
		logic [DIFF_W-1:0] ax;
		logic [DIFF_W-1:0] ay;
		logic              nx;
		logic              ny;
		logic [MASS_W-1:0] m1;
		logic [MASS_W-1:0] m2;
		logic              dg;
		logic              ovf;
		logic [SQ_W-1:0]   s;
		logic [SQ_W-1:0]   srem;
		logic [ROOT_W-1:0] root;
		logic [DIV_W-1:0]  nrem;
		logic [MAG_W-1:0]  q;
	} root_t;

	typedef struct packed {
		logic [CX_W-1:0]   qx;
		logic [CX_W-1:0]   qy;
		logic [ROOT_W:0]   rx;
		logic [ROOT_W:0]   ry;
		logic [ROOT_W-1:0] d;
		logic [MASS_W-1:0] m1;
		logic [MASS_W-1:0] m2;
		logic              nx;
		logic              ny;
		logic              dg;
		logic              sat;
	} comp_t;

	typedef struct packed {
		logic [CX_W-1:0]                cx;
		logic [CX_W-1:0]                cy;
		logic [LANES-1:0][ACC_Q_W-1:0]  aq;
		logic [LANES-1:0][MASS_W:0]     ar;
		logic [LANES-1:0]               aov;
		logic [MASS_W-1:0]              m1;
		logic [MASS_W-1:0]              m2;
		logic                           nx;
		logic                           ny;
		logic                           dg;
		logic                           sat;
	} acc_t;

	function automatic logic [POS_W:0] clip32(input logic neg, input logic [CX_W-1:0] mag);
		logic [POS_W:0] r;
		if (!neg) begin
			if (mag > CX_W'(32'h7FFF_FFFF)) r = {1'b1, 32'h7FFF_FFFF};
			else r = {1'b0, mag[POS_W-1:0]};
		end else begin
			if (mag > CX_W'(32'h8000_0000)) r = {1'b1, 32'h8000_0000};
			else r = {1'b0, POS_W'(-mag[POS_W-1:0])};
		end
		return r;
	endfunction

	// Configuration register.
	logic [G_W-1:0] g_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) g_q <= G_RESET;
		else if (cfg_we) g_q <= cfg_wdata;
	end

	// One enable for the whole pipeline: it moves unless a finished result is
	// held by the receiver.
	logic adv;
	assign adv = !result.valid || result.ready;
	assign pair.ready = adv;

	logic [NST-1:0] vld_s;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s <= '0;
		else if (adv) vld_s <= {vld_s[NST-2:0], pair.valid};
	end
	assign result.valid = vld_s[NST-1];

	// Stage 1: exact differences and their magnitudes.
	logic signed [DIFF_W-1:0] dx_c, dy_c;
	logic [DIFF_W-1:0] ax_s1, ay_s1;
	logic nx_s1, ny_s1, mz_s1;
	logic [MASS_W-1:0] m1_s1, m2_s1;
	logic [G_W-1:0] g_s1;

	always_comb begin
		dx_c = DIFF_W'(pair.data.second_pos_x) - DIFF_W'(pair.data.first_pos_x);
		dy_c = DIFF_W'(pair.data.second_pos_y) - DIFF_W'(pair.data.first_pos_y);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nx_s1 <= dx_c[DIFF_W-1];
			ny_s1 <= dy_c[DIFF_W-1];
			ax_s1 <= dx_c[DIFF_W-1] ? DIFF_W'(-dx_c) : DIFF_W'(dx_c);
			ay_s1 <= dy_c[DIFF_W-1] ? DIFF_W'(-dy_c) : DIFF_W'(dy_c);
			m1_s1 <= pair.data.first_mass;
			m2_s1 <= pair.data.second_mass;
			mz_s1 <= (pair.data.first_mass == '0) || (pair.data.second_mass == '0);
			g_s1  <= g_q;
		end
	end

	// Stage 2: squares and the first half of G*m1*m2.
	logic [2*DIFF_W-1:0] sqx_s2, sqy_s2;
	logic [G_W+MASS_W-1:0] gm1_s2;
	logic [DIFF_W-1:0] ax_s2, ay_s2;
	logic nx_s2, ny_s2, mz_s2;
	logic [MASS_W-1:0] m1_s2, m2_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			sqx_s2 <= ax_s1 * ax_s1;
			sqy_s2 <= ay_s1 * ay_s1;
			gm1_s2 <= g_s1 * m1_s1;
			ax_s2  <= ax_s1;
			ay_s2  <= ay_s1;
			nx_s2  <= nx_s1;
			ny_s2  <= ny_s1;
			mz_s2  <= mz_s1;
			m1_s2  <= m1_s1;
			m2_s2  <= m2_s1;
		end
	end

	// Stage 3: squared distance and the full product.
	logic [SQ_W-1:0] s_s3;
	logic [PROD_W-1:0] p_s3;
	logic [DIFF_W-1:0] ax_s3, ay_s3;
	logic nx_s3, ny_s3, mz_s3;
	logic [MASS_W-1:0] m1_s3, m2_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			s_s3  <= SQ_W'(sqx_s2) + SQ_W'(sqy_s2);
			p_s3  <= PROD_W'(gm1_s2) * PROD_W'(m2_s2);
			ax_s3 <= ax_s2;
			ay_s3 <= ay_s2;
			nx_s3 <= nx_s2;
			ny_s3 <= ny_s2;
			mz_s3 <= mz_s2;
			m1_s3 <= m1_s2;
			m2_s3 <= m2_s2;
		end
	end

	// Square root and force magnitude: a root bit per stage, a magnitude bit in
	// the first 32. The root keeps S - d^2 as a running remainder; the magnitude
	// is a restoring division of the scaled product by S.
	root_t rt_init;
	root_t rt_s [0:ROOT_STEPS];
	root_t rt_n [1:ROOT_STEPS];

	always_comb begin
		logic [DIV_W-1:0] num;
		num = DIV_W'({p_s3, {SH{1'b0}}});
		rt_init.ax   = ax_s3;
		rt_init.ay   = ay_s3;
		rt_init.nx   = nx_s3;
		rt_init.ny   = ny_s3;
		rt_init.m1   = m1_s3;
		rt_init.m2   = m2_s3;
		rt_init.dg   = mz_s3 || (s_s3 == '0);
		rt_init.ovf  = num >= (DIV_W'(s_s3) << MAG_W);
		rt_init.s    = s_s3;
		rt_init.srem = s_s3;
		rt_init.root = '0;
		rt_init.nrem = num;
		rt_init.q    = '0;
	end

	always_comb begin
		root_t bt;
		logic [TW-1:0] trial;
		logic [DIV_W-1:0] dt;
		for (int k = 1; k <= ROOT_STEPS; k++) begin
			bt = rt_s[k-1];
			trial = (TW'(bt.root) << (ROOT_STEPS - k + 1)) |
				(TW'(1) << (2 * (ROOT_STEPS - k)));
			if (TW'(bt.srem) >= trial) begin
				bt.srem = SQ_W'(TW'(bt.srem) - trial);
				bt.root[ROOT_STEPS-k] = 1'b1;
			end
			if (k <= MAG_W) begin
				dt = DIV_W'(bt.s) << (MAG_W - k);
				if (bt.nrem >= dt) begin
					bt.nrem = bt.nrem - dt;
					bt.q = {bt.q[MAG_W-2:0], 1'b1};
				end else begin
					bt.q = {bt.q[MAG_W-2:0], 1'b0};
				end
			end
			rt_n[k] = bt;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rt_s[0] <= rt_init;
			for (int k = 1; k <= ROOT_STEPS; k++) rt_s[k] <= rt_n[k];
		end
	end

	// Components: magnitude times |dx|, |dy| (kept modulo 2^64), then divided
	// by the distance one quotient bit per stage.
	comp_t cp_init;
	comp_t cp_s [0:CX_W];
	comp_t cp_n [1:CX_W];

	always_comb begin
		logic [MAG_W-1:0] mag;
		mag = rt_s[ROOT_STEPS].ovf ? '1 : rt_s[ROOT_STEPS].q;
		cp_init.qx  = CX_W'(mag) * CX_W'(rt_s[ROOT_STEPS].ax);
		cp_init.qy  = CX_W'(mag) * CX_W'(rt_s[ROOT_STEPS].ay);
		cp_init.rx  = '0;
		cp_init.ry  = '0;
		cp_init.d   = rt_s[ROOT_STEPS].root;
		cp_init.m1  = rt_s[ROOT_STEPS].m1;
		cp_init.m2  = rt_s[ROOT_STEPS].m2;
		cp_init.nx  = rt_s[ROOT_STEPS].nx;
		cp_init.ny  = rt_s[ROOT_STEPS].ny;
		cp_init.dg  = rt_s[ROOT_STEPS].dg;
		cp_init.sat = rt_s[ROOT_STEPS].ovf;
	end

	always_comb begin
		comp_t ct;
		logic [ROOT_W:0] r;
		for (int k = 1; k <= CX_W; k++) begin
			ct = cp_s[k-1];
			r = {ct.rx[ROOT_W-1:0], ct.qx[CX_W-1]};
			ct.qx = {ct.qx[CX_W-2:0], 1'b0};
			if (r >= {1'b0, ct.d}) begin
				r = r - {1'b0, ct.d};
				ct.qx[0] = 1'b1;
			end
			ct.rx = r;
			r = {ct.ry[ROOT_W-1:0], ct.qy[CX_W-1]};
			ct.qy = {ct.qy[CX_W-2:0], 1'b0};
			if (r >= {1'b0, ct.d}) begin
				r = r - {1'b0, ct.d};
				ct.qy[0] = 1'b1;
			end
			ct.ry = r;
			cp_n[k] = ct;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cp_s[0] <= cp_init;
			for (int k = 1; k <= CX_W; k++) cp_s[k] <= cp_n[k];
		end
	end

	// Accelerations: four lanes (x and y over m1, x and y over m2). A quotient
	// of 2^33 or more is flagged up front; only the low 33 bits are developed.
	acc_t ac_init;
	acc_t ac_s [0:ACC_Q_W];
	acc_t ac_n [1:ACC_Q_W];

	always_comb begin
		logic [CX_W-1:0] num;
		logic [MASS_W-1:0] md;
		ac_init.cx  = cp_s[CX_W].qx;
		ac_init.cy  = cp_s[CX_W].qy;
		ac_init.m1  = cp_s[CX_W].m1;
		ac_init.m2  = cp_s[CX_W].m2;
		ac_init.nx  = cp_s[CX_W].nx;
		ac_init.ny  = cp_s[CX_W].ny;
		ac_init.dg  = cp_s[CX_W].dg;
		ac_init.sat = cp_s[CX_W].sat;
		for (int l = 0; l < LANES; l++) begin
			num = (l % 2 == 0) ? cp_s[CX_W].qx : cp_s[CX_W].qy;
			num = num << MASS_FRAC;
			md  = (l < 2) ? cp_s[CX_W].m1 : cp_s[CX_W].m2;
			ac_init.aov[l] = num >= (CX_W'(md) << ACC_Q_W);
			ac_init.ar[l]  = (MASS_W + 1)'(num >> ACC_Q_W);
			ac_init.aq[l]  = num[ACC_Q_W-1:0];
		end
	end

	always_comb begin
		acc_t at;
		logic [MASS_W:0] r;
		logic [MASS_W-1:0] md;
		for (int k = 1; k <= ACC_Q_W; k++) begin
			at = ac_s[k-1];
			for (int l = 0; l < LANES; l++) begin
				md = (l < 2) ? at.m1 : at.m2;
				r = {at.ar[l][MASS_W-1:0], at.aq[l][ACC_Q_W-1]};
				at.aq[l] = {at.aq[l][ACC_Q_W-2:0], 1'b0};
				if (r >= {1'b0, md}) begin
					r = r - {1'b0, md};
					at.aq[l][0] = 1'b1;
				end
				at.ar[l] = r;
			end
			ac_n[k] = at;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ac_s[0] <= ac_init;
			for (int k = 1; k <= ACC_Q_W; k++) ac_s[k] <= ac_n[k];
		end
	end

	// Output register: signs, clipping, and the degenerate override.
	logic [LANES-1:0][CX_W-1:0] amag_c;
	logic [POS_W:0] fx_c, fy_c, a1x_c, a1y_c, a2x_c, a2y_c;
	result_t res_c;

	always_comb begin
		for (int l = 0; l < LANES; l++)
			amag_c[l] = ac_s[ACC_Q_W].aov[l] ? '1 : CX_W'(ac_s[ACC_Q_W].aq[l]);
		fx_c  = clip32(ac_s[ACC_Q_W].nx, ac_s[ACC_Q_W].cx);
		fy_c  = clip32(ac_s[ACC_Q_W].ny, ac_s[ACC_Q_W].cy);
		a1x_c = clip32(ac_s[ACC_Q_W].nx, amag_c[0]);
		a1y_c = clip32(ac_s[ACC_Q_W].ny, amag_c[1]);
		a2x_c = clip32(!ac_s[ACC_Q_W].nx, amag_c[2]);
		a2y_c = clip32(!ac_s[ACC_Q_W].ny, amag_c[3]);
		res_c = '0;
		if (ac_s[ACC_Q_W].dg) begin
			res_c.degenerate = 1'b1;
		end else begin
			res_c.force_x        = fx_c[POS_W-1:0];
			res_c.force_y        = fy_c[POS_W-1:0];
			res_c.first_accel_x  = a1x_c[POS_W-1:0];
			res_c.first_accel_y  = a1y_c[POS_W-1:0];
			res_c.second_accel_x = a2x_c[POS_W-1:0];
			res_c.second_accel_y = a2y_c[POS_W-1:0];
			res_c.saturated      = ac_s[ACC_Q_W].sat || fx_c[POS_W] ||
				fy_c[POS_W] || a1x_c[POS_W] || a1y_c[POS_W] ||
				a2x_c[POS_W] || a2y_c[POS_W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) result.data <= res_c;
	end

endmodule
`default_nettype wire

[src/pga_checker.sv]
`default_nettype none
module pga_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             pair_ready,
	input logic             res_valid,
	input logic             res_ready,
	input pga_pkg::result_t res
);

	// The pipeline takes a pair exactly when its output stage can move.
	a_ready_follows_output: assert property (@(posedge clk) disable iff (!arst_n)
		pair_ready == (!res_valid || res_ready))
		else $error("pair ready does not follow the output stage");

	// A held result stays put until taken.
	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("stalled result changed");

	// Degenerate pairs give an all-zero word with no saturation.
	a_degenerate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.degenerate |-> res.force_x == 0 && res.force_y == 0 &&
			res.first_accel_x == 0 && res.first_accel_y == 0 &&
			res.second_accel_x == 0 && res.second_accel_y == 0 && !res.saturated)
		else $error("degenerate result not cleared");

	// The first body is pulled along the force, the second against it.
	a_accel_signs: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.force_x > 0 |-> res.first_accel_x >= 0 &&
			res.second_accel_x <= 0)
		else $error("acceleration signs disagree with the force");

endmodule

bind pairwise_gravity_acceleration pga_checker u_pga_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.pair_ready (pair.ready),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res        (result.data)
);
`default_nettype wire

[sim/pga_gravity_tb_if.sv]
`timescale 1ns / 1ps
// The block's own interfaces live in src/pga_if.sv; this file holds the reset
// length and marks that the testbench reuses those interfaces unchanged.
package pga_tb_notes_pkg;
	localparam int RESET_CYCLES = 9;
endpackage

[sim/pairwise_gravity_acceleration_test.sv]
`timescale 1ns / 1ps
module pairwise_gravity_acceleration_test;
	import pga_pkg::*;

	localparam int PIPE_LATENCY = 138;
	localparam int CYCLE_LIMIT = 200000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [G_W-1:0] cfg_wdata;

	pga_pair_if pair_ch();
	pga_result_if result_ch();

	pairwise_gravity_acceleration #(.FRAC_BITS(16)) dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.pair(pair_ch.sink), .result(result_ch.source)
	);

	// The gravity constant as the predictor currently sees it.
	logic [G_W-1:0] grav_const;

	pair_t pending_pairs[$];
	result_t expected_forces[$];
	int mismatches;
	int cycles;
	bit quiet_tail;
	int send_gap;
	int recv_gap;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Clip a magnitude with a sign into a 32-bit signed word.
	function automatic logic [31:0] clip_word(input bit neg, input logic [127:0] mag,
			inout bit sat);
		if (!neg) begin
			if (mag > 128'h7FFF_FFFF) begin
				sat = 1'b1;
				return 32'h7FFF_FFFF;
			end
			return mag[31:0];
		end
		if (mag > 128'h8000_0000) begin
			sat = 1'b1;
			return 32'h8000_0000;
		end
		return -mag[31:0];
	endfunction

	// Force and acceleration increments for one pair, exact integer arithmetic.
	function automatic result_t gravity_of(input pair_t p, input logic [G_W-1:0] g);
		result_t r;
		logic signed [33:0] dx, dy;
		logic [127:0] ax, ay, s, d, c, num, mag, cx, cy, prod;
		bit sat;
		r = '0;
		sat = 1'b0;
		dx = 34'(p.second_pos_x) - 34'(p.first_pos_x);
		dy = 34'(p.second_pos_y) - 34'(p.first_pos_y);
		ax = dx < 0 ? 128'(-dx) : 128'(dx);
		ay = dy < 0 ? 128'(-dy) : 128'(dy);
		s = ax * ax + ay * ay;
		if (s == 0 || p.first_mass == 0 || p.second_mass == 0) begin
			r.degenerate = 1'b1;
			return r;
		end
		d = 0;
		for (int b = 33; b >= 0; b--) begin
			c = d | (128'd1 << b);
			if (c * c <= s)
				d = c;
		end
		prod = 128'(g) * 128'(p.first_mass) * 128'(p.second_mass);
		// Q.16 cubed over Q.8 squared leaves a shift of 32.
		num = prod << 32;
		if (num >= (s << 32)) begin
			mag = 128'hFFFF_FFFF;
			sat = 1'b1;
		end else
			mag = num / s;
		cx = mag * ax / d;
		cy = mag * ay / d;
		r.force_x = clip_word(dx < 0, cx, sat);
		r.force_y = clip_word(dy < 0, cy, sat);
		r.first_accel_x = clip_word(dx < 0, (cx << 8) / p.first_mass, sat);
		r.first_accel_y = clip_word(dy < 0, (cy << 8) / p.first_mass, sat);
		r.second_accel_x = clip_word(!(dx < 0), (cx << 8) / p.second_mass, sat);
		r.second_accel_y = clip_word(!(dy < 0), (cy << 8) / p.second_mass, sat);
		r.saturated = sat;
		return r;
	endfunction

	function automatic logic [31:0] rand_pos();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'h8000_0000;
			2: return 32'h7FFF_FFFF;
			default: return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
		endcase
	endfunction

	function automatic logic [23:0] rand_mass();
		case ($urandom_range(0, 7))
			0: return 24'hFF_FFFF;
			1: return 24'd0;
			2: return 24'($urandom);
			default: return 24'($urandom_range(1, 24'h00_FFFF));
		endcase
	endfunction

	function automatic pair_t make_pair(input logic [31:0] x1, y1, x2, y2,
			input logic [23:0] m1, m2);
		pair_t p;
		p.first_pos_x = x1;
		p.first_pos_y = y1;
		p.second_pos_x = x2;
		p.second_pos_y = y2;
		p.first_mass = m1;
		p.second_mass = m2;
		return p;
	endfunction

	// Append one pair to the end of the pending list.
	function automatic void queue_pair(input pair_t p);
		pending_pairs.insert(pending_pairs.size(), p);
	endfunction

	// Wait until the pipeline has drained, then let it settle before a write.
	task automatic wait_drained();
		while (pending_pairs.size() != 0 || expected_forces.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 10) @(posedge clk);
	endtask

	task automatic write_gravity(input logic [G_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		grav_const = value;
	endtask

	// Queue one phase of pairs: a directed part when asked, then random ones.
	task automatic queue_phase(input int count, input bit directed);
		logic [31:0] x, y;
		if (directed) begin
			queue_pair(make_pair(0, 0, 0, 0, 24'h100, 24'h100));
			queue_pair(make_pair(0, 0, 32'h1_0000, 0, 0, 24'h100));
			queue_pair(make_pair(0, 0, 32'h1_0000, 0, 24'h100, 0));
			queue_pair(make_pair(0, 0, 32'h1_0000, 0, 24'h100, 24'h100));
			queue_pair(make_pair(0, 0, 0, 32'hFFFF_0000, 24'h100, 24'h100));
			queue_pair(make_pair(0, 0, 1, 1, 24'hFF_FFFF, 24'hFF_FFFF));
			queue_pair(make_pair(0, 0, 1, 0, 24'd1, 24'd1));
			queue_pair(make_pair(32'h8000_0000, 32'h8000_0000,
				32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF));
			queue_pair(make_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF,
				32'h8000_0000, 32'h8000_0000, 24'd1, 24'd1));
			queue_pair(make_pair(32'h8000_0000, 0, 32'h7FFF_FFFF, 0,
				24'd1, 24'hFF_FFFF));
			queue_pair(make_pair(0, 32'h7FFF_FFFF, 0, 32'h8000_0000,
				24'hFF_FFFF, 24'd1));
			queue_pair(make_pair(32'h0003_0000, 32'hFFFC_0000,
				32'hFFFD_0000, 32'h0004_0000, 24'h200, 24'h80));
			queue_pair(make_pair(32'h1234_5678, 32'h1234_5678,
				32'h1234_5678, 32'h1234_5678, 24'hFF_FFFF, 24'hFF_FFFF));
		end
		for (int i = 0; i < count; i++) begin
			x = rand_pos();
			y = rand_pos();
			// Now and then the bodies coincide or sit very close.
			case ($urandom_range(0, 9))
				0: queue_pair(make_pair(x, y, x, y, rand_mass(), rand_mass()));
				1: queue_pair(make_pair(x, y, x + $urandom_range(0, 3),
					y - $urandom_range(0, 3), rand_mass(), rand_mass()));
				default: queue_pair(make_pair(x, y, rand_pos(), rand_pos(),
					rand_mass(), rand_mass()));
			endcase
		end
	endtask

	// Driver: offers the oldest pending pair, idles in short random bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_ch.valid <= 1'b0;
			pair_ch.data <= '0;
			send_gap <= 0;
		end else begin
			automatic bit taken = pair_ch.valid && pair_ch.ready;
			automatic int gap = send_gap;
			if (taken) begin
				expected_forces.insert(expected_forces.size(),
					gravity_of(pending_pairs[0], grav_const));
				pending_pairs.delete(0);
			end
			if (!pair_ch.valid || taken) begin
				if (gap > 0) begin
					gap--;
					pair_ch.valid <= 1'b0;
				end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
					gap = $urandom_range(0, 2);
					pair_ch.valid <= 1'b0;
				end else if (pending_pairs.size() != 0) begin
					pair_ch.valid <= 1'b1;
					pair_ch.data <= pending_pairs[0];
				end else
					pair_ch.valid <= 1'b0;
			end
			send_gap <= gap;
		end
	end

	// Monitor: takes result words, stalls in short random bursts, and checks
	// each word against the oldest expected force.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (expected_forces.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result word %h", result_ch.data);
				end else begin
					automatic result_t want = expected_forces[0];
					expected_forces.delete(0);
					if (want !== result_ch.data) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %h got %h", want, result_ch.data);
					end
				end
			end
			if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				result_ch.ready <= 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				recv_gap <= $urandom_range(0, 2);
				result_ch.ready <= 1'b0;
			end else
				result_ch.ready <= 1'b1;
		end
	end

	// Watchdog on total run time.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		grav_const = G_RESET;
		quiet_tail = 1'b0;
		repeat (pga_tb_notes_pkg::RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Reset value of the gravity constant first.
		queue_phase(150, 1'b1);
		// Sender holds off until every result is back.
		wait_drained();
		write_gravity(16'hFFFF);
		queue_phase(150, 1'b1);
		wait_drained();
		write_gravity(16'd0);
		queue_phase(60, 1'b1);
		wait_drained();
		write_gravity(16'd1);
		queue_phase(150, 1'b0);
		wait_drained();
		write_gravity(16'($urandom));
		queue_phase(120, 1'b0);
		wait_drained();
		// Last part runs with no idling on either side.
		quiet_tail = 1'b1;
		write_gravity(16'd3000);
		queue_phase(120, 1'b0);
		wait_drained();

		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
